### rtl/core/psv_pkg.sv
package psv_pkg;

   // Widths of the transfer fields and of the register file.
   localparam int CHAR_W      = 8;
   localparam int PROVINCE_W  = 7;
   localparam int MASK_W      = 26;
   localparam int MAXLEN_W    = 9;
   localparam int CSR_ADDR_W  = 4;
   localparam int CSR_DATA_W  = 32;

   // Character codes used by the normalizer and the structure checker.
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_DASH    = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_W-1:0] CASE_DIFF  = 8'h20;

   localparam logic [PROVINCE_W-1:0] PROVINCE_MAX = 7'd81;
   localparam logic [3:0] LAST_FIRST_DIGIT = 4'd8;
   localparam logic [3:0] KEPT_SAT         = 4'd9;
   localparam logic [3:0] KEPT_MAX_OK      = 4'd8;
   localparam logic [3:0] KEPT_MIN_PLATE   = 4'd6;
   localparam logic [3:0] DIGITS_SAT       = 4'd15;
   localparam logic [2:0] LETTERS_CAP      = 3'd4;
   localparam logic [2:0] LETTERS_MAX      = 3'd3;

   typedef enum logic [1:0] {
      PH_PROVINCE = 2'd0,
      PH_LETTERS  = 2'd1,
      PH_DIGITS   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CSR_LETTER_MASK = 2'd0,
      CSR_STRIP_SPACE = 2'd1,
      CSR_STRIP_DASH  = 2'd2,
      CSR_MAX_LENGTH  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [3:0]            kept_count;
      logic [3:0]            first_digit;
      logic [PROVINCE_W-1:0] code_value;
      phase_type             phase;
      logic [2:0]            letters_seen;
      logic [3:0]            digits_seen;
      logic                  poisoned;
      logic                  shape_error;
   } scan_state_type;

   localparam scan_state_type SCAN_CLEAR = '{
      kept_count:   '0,
      first_digit:  '0,
      code_value:   '0,
      phase:        PH_PROVINCE,
      letters_seen: '0,
      digits_seen:  '0,
      poisoned:     1'b0,
      shape_error:  1'b0
   };

   typedef struct packed {
      logic [MASK_W-1:0] letter_mask;
      logic              strip_space;
      logic              strip_dash;
   } scan_cfg_type;

   typedef struct packed {
      logic                  plate_ok;
      logic                  prefix_ok;
      logic [PROVINCE_W-1:0] province;
   } scan_result_type;

endpackage

### rtl/core/psv_req_if.sv
interface psv_req_if import psv_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_text;

   modport source (output valid, output char_code, output end_of_text, input ready);
   modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

### rtl/core/psv_rsp_if.sv
interface psv_rsp_if import psv_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  plate_ok;
   logic                  prefix_ok;
   logic [PROVINCE_W-1:0] province;
   logic                  end_marker;

   modport source (output valid, output plate_ok, output prefix_ok, output province,
                   output end_marker, input ready);
   modport sink   (input valid, input plate_ok, input prefix_ok, input province,
                   input end_marker, output ready);
endinterface

### rtl/core/psv_step.sv
// Normalizes one character and advances the plate structure checker by one step.
module psv_step import psv_pkg::*; (
   input  logic [CHAR_W-1:0] char_code,
   input  logic              too_long,
   input  scan_cfg_type      cfg,
   input  scan_state_type    state_cur,
   output scan_state_type    state_nxt,
   output scan_result_type   result
);

   logic              high_byte;
   logic              is_space;
   logic              dropped;
   logic              take;
   logic [CHAR_W-1:0] upper;
   logic              is_digit;
   logic              is_letter;
   logic [3:0]        digit_val;
   logic [4:0]        letter_idx;
   logic [PROVINCE_W-1:0] code;
   logic [3:0]        digit_limit;
   logic              dead;

   always_comb begin
      high_byte = char_code[CHAR_W-1];
      is_space  = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
                  (char_code == CH_CR) || (char_code == CH_LF);
      dropped   = (cfg.strip_space && is_space) || (cfg.strip_dash && char_code == CH_DASH);
      take      = !high_byte && !dropped && !state_cur.poisoned;

      if (char_code >= CH_LOWER_A && char_code <= CH_LOWER_Z) begin
         upper = char_code - CASE_DIFF;
      end else begin
         upper = char_code;
      end
      is_digit   = (upper >= CH_ZERO) && (upper <= CH_NINE);
      digit_val  = upper[3:0];
      letter_idx = 5'(upper - CH_UPPER_A);
      is_letter  = (upper >= CH_UPPER_A) && (upper <= CH_UPPER_Z) &&
                   cfg.letter_mask[letter_idx];
      code       = 7'(state_cur.first_digit) * 7'd10 + 7'(digit_val);

      state_nxt = state_cur;
      if (high_byte) begin
         state_nxt.poisoned = 1'b1;
      end
      if (take) begin
         if (state_cur.kept_count == 4'd0) begin
            if (is_digit) begin
               state_nxt.first_digit = digit_val;
            end else begin
               state_nxt.shape_error = 1'b1;
            end
         end else if (state_cur.kept_count == 4'd1) begin
            if (!state_cur.shape_error && is_digit) begin
               if (code == '0 || code > PROVINCE_MAX) begin
                  state_nxt.shape_error = 1'b1;
               end else begin
                  state_nxt.code_value = code;
               end
            end else begin
               state_nxt.shape_error = 1'b1;
            end
            state_nxt.phase = PH_LETTERS;
         end else if (state_cur.phase == PH_LETTERS) begin
            if (is_letter) begin
               if (state_cur.letters_seen < LETTERS_CAP) begin
                  state_nxt.letters_seen = state_cur.letters_seen + 3'd1;
               end
               if (state_nxt.letters_seen > LETTERS_MAX) begin
                  state_nxt.shape_error = 1'b1;
               end
            end else if (is_digit && state_cur.letters_seen != '0) begin
               state_nxt.phase       = PH_DIGITS;
               state_nxt.digits_seen = 4'd1;
            end else begin
               state_nxt.shape_error = 1'b1;
            end
         end else begin
            if (is_digit) begin
               if (state_cur.digits_seen < DIGITS_SAT) begin
                  state_nxt.digits_seen = state_cur.digits_seen + 4'd1;
               end
            end else begin
               state_nxt.shape_error = 1'b1;
            end
         end
         if (state_cur.kept_count < KEPT_SAT) begin
            state_nxt.kept_count = state_cur.kept_count + 4'd1;
         end
      end

      case (state_nxt.letters_seen)
         3'd1:    digit_limit = 4'd5;
         3'd2:    digit_limit = 4'd4;
         3'd3:    digit_limit = 4'd3;
         default: digit_limit = 4'd0;
      endcase

      dead   = state_nxt.poisoned || too_long || state_nxt.kept_count == '0;
      result = '0;
      if (!dead) begin
         if (state_nxt.kept_count >= 4'd2) begin
            result.province = state_nxt.code_value;
         end
         if (!state_nxt.shape_error && state_nxt.kept_count <= KEPT_MAX_OK) begin
            if (state_nxt.kept_count == 4'd1) begin
               result.prefix_ok = (state_nxt.first_digit <= LAST_FIRST_DIGIT);
            end else if (state_nxt.phase == PH_LETTERS) begin
               result.prefix_ok = 1'b1;
            end else begin
               result.prefix_ok = (state_nxt.digits_seen <= digit_limit);
            end
            result.plate_ok = (state_nxt.kept_count >= KEPT_MIN_PLATE) &&
                              (state_nxt.phase == PH_DIGITS) && (digit_limit != '0) &&
                              ((state_nxt.digits_seen == digit_limit) ||
                               (state_nxt.digits_seen + 4'd1 == digit_limit));
         end
      end
   end

endmodule

### rtl/core/plate_string_validator.sv
// Plate string validator. Characters of a plate string arrive one per transfer on
// req_stream, the last one flagged by end_of_text, and every character yields exactly
// one result transfer on rsp_stream: whether the text so far is a complete valid
// plate, whether it can still begin one, and the province code once two digits have
// been seen. Spaces, tabs, line breaks and hyphens are dropped when the matching
// register bit is set, lower case is folded to upper case, and a byte of 128 or
// above, or a string longer than max_length raw bytes, kills the rest of the
// string. The string state clears after the flagged last character. Throughput is
// one character per clock cycle while rsp_stream is ready, set by the single input
// register and the single result register between which the whole update of the
// scan counters happens. A character is held in the input register and then in
// the result register, from which its result is transferred out. The input side
// keeps taking characters while a finished result waits, until both registers
// are full. Registers are written through the APB-style port at byte addresses
// 0 (letter mask), 4 (strip space), 8 (strip dash) and 12 (max length); the
// user must write them only while no string is in flight, as the block itself
// does not enforce it.
module plate_string_validator import psv_pkg::*; #(
   parameter int MAX_RAW_LENGTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   psv_req_if.sink               req_stream,
   psv_rsp_if.source             rsp_stream,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // The raw byte counter saturates one past MAX_RAW_LENGTH.
   localparam int RAW_W = $clog2(MAX_RAW_LENGTH + 2);
   localparam int CMP_W = (RAW_W > MAXLEN_W) ? RAW_W : MAXLEN_W;
   localparam logic [RAW_W-1:0] RAW_SAT = RAW_W'(MAX_RAW_LENGTH + 1);

   // Configuration registers.
   logic [MASK_W-1:0]   letter_mask_ff;
   logic                strip_space_ff;
   logic                strip_dash_ff;
   logic [MAXLEN_W-1:0] max_length_ff;
   logic                csr_write;
   csr_index_type       csr_index;

   // Input register.
   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_char_ff;
   logic              in_last_ff;

   // Per-string scan state.
   scan_state_type   scan_ff;
   scan_state_type   scan_in;
   logic [RAW_W-1:0] raw_count_ff;
   logic [RAW_W-1:0] raw_count_in;
   logic             too_long;

   // Result register.
   logic            rsp_valid_ff;
   scan_result_type rsp_ff;
   scan_result_type rsp_in;
   logic            rsp_last_ff;

   logic         advance;
   scan_cfg_type cfg;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = csr_index_type'(paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_mask_ff <= '1;
         strip_space_ff <= 1'b1;
         strip_dash_ff  <= 1'b1;
         max_length_ff  <= MAXLEN_W'(MAX_RAW_LENGTH);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_LETTER_MASK: letter_mask_ff <= pwdata[MASK_W-1:0];
            CSR_STRIP_SPACE: strip_space_ff <= pwdata[0];
            CSR_STRIP_DASH:  strip_dash_ff  <= pwdata[0];
            CSR_MAX_LENGTH:  max_length_ff  <= pwdata[MAXLEN_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         CSR_LETTER_MASK: prdata = CSR_DATA_W'(letter_mask_ff);
         CSR_STRIP_SPACE: prdata = CSR_DATA_W'(strip_space_ff);
         CSR_STRIP_DASH:  prdata = CSR_DATA_W'(strip_dash_ff);
         CSR_MAX_LENGTH:  prdata = CSR_DATA_W'(max_length_ff);
      endcase
   end

   // A character moves from the input register to the result register whenever the
   // result register is empty or its content is being transferred out.
   assign advance          = in_valid_ff && (!rsp_valid_ff || rsp_stream.ready);
   assign req_stream.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_stream.ready) begin
         in_valid_ff <= req_stream.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_stream.valid && req_stream.ready) begin
         in_char_ff <= req_stream.char_code;
         in_last_ff <= req_stream.end_of_text;
      end
   end

   // The length check uses the count that includes the current character.
   always_comb begin
      if (raw_count_ff < RAW_SAT) begin
         raw_count_in = raw_count_ff + RAW_W'(1);
      end else begin
         raw_count_in = raw_count_ff;
      end
      too_long = CMP_W'(raw_count_in) > CMP_W'(max_length_ff);
   end

   assign cfg = '{letter_mask: letter_mask_ff, strip_space: strip_space_ff,
                  strip_dash: strip_dash_ff};

   psv_step u_step (
      .char_code (in_char_ff),
      .too_long  (too_long),
      .cfg       (cfg),
      .state_cur (scan_ff),
      .state_nxt (scan_in),
      .result    (rsp_in)
   );

   // The scan state advances once per character and clears after the last one.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff      <= SCAN_CLEAR;
         raw_count_ff <= '0;
      end else if (advance) begin
         if (in_last_ff) begin
            scan_ff      <= SCAN_CLEAR;
            raw_count_ff <= '0;
         end else begin
            scan_ff      <= scan_in;
            raw_count_ff <= raw_count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_stream.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff      <= rsp_in;
         rsp_last_ff <= in_last_ff;
      end
   end

   assign rsp_stream.valid      = rsp_valid_ff;
   assign rsp_stream.plate_ok   = rsp_ff.plate_ok;
   assign rsp_stream.prefix_ok  = rsp_ff.prefix_ok;
   assign rsp_stream.province   = rsp_ff.province;
   assign rsp_stream.end_marker = rsp_last_ff;

endmodule
